// ===== design/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int NUM_LANES  = 3;
    localparam int WEIGHT_W   = 17;   // holds 256*256
    localparam int ACC_W      = 24;   // 255 * 65536 fits
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int IN_DIM_W   = 9;
    localparam int OUT_DIM_W  = 13;
    localparam int STEP_W     = 24;
    localparam int OUT_CNT_W  = 12;
    localparam int OUT_MAX    = 4096;

    localparam logic [IN_DIM_W-1:0]  IN_WIDTH_RST   = 9'd256;
    localparam logic [IN_DIM_W-1:0]  IN_HEIGHT_RST  = 9'd256;
    localparam logic [OUT_DIM_W-1:0] OUT_WIDTH_RST  = 13'd512;
    localparam logic [OUT_DIM_W-1:0] OUT_HEIGHT_RST = 13'd512;
    localparam logic [STEP_W-1:0]    X_STEP_RST     = 24'd32640;
    localparam logic [STEP_W-1:0]    Y_STEP_RST     = 24'd32640;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH   = 3'd0,
        REG_IN_HEIGHT  = 3'd1,
        REG_OUT_WIDTH  = 3'd2,
        REG_OUT_HEIGHT = 3'd3,
        REG_X_STEP     = 3'd4,
        REG_Y_STEP     = 3'd5
    } bis_reg_e;

    typedef struct packed {
        logic clear;
        logic mac_en;
    } bis_lane_ctl_t;

    typedef struct packed {
        logic load;
        logic last;
    } bis_out_ctl_t;

endpackage

// ===== design/bis_if.sv =====
// ----------------------------------------------------------------------------
// bis_if
// Request and result channel interfaces of the bilinear image scaler.
// ----------------------------------------------------------------------------
interface bis_cmd_if import bis_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;

    modport source (output valid, command, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

interface bis_pix_if import bis_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_last;

    modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

// ===== design/bis_ram.sv =====
// ----------------------------------------------------------------------------
// bis_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bis_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== design/bis_lane.sv =====
// ----------------------------------------------------------------------------
// bis_lane
// One color channel: accumulates neighbor * weight over the four reads.
// ----------------------------------------------------------------------------
module bis_lane import bis_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  bis_lane_ctl_t       ctl,
    input  logic [CHAN_W-1:0]   pix,
    input  logic [WEIGHT_W-1:0] weight,
    output logic [CHAN_W-1:0]   chan
);

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] product;

    assign product = ACC_W'(pix) * ACC_W'(weight);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.mac_en)
        begin
            acc_next = acc_reg + product;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // weights sum to 65536, so the top byte is the truncated channel
    assign chan = acc_reg[ACC_W-1 -: CHAN_W];

    a_clear_not_mid_sum: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.clear && ctl.mac_en))
        else $error("lane cleared while accumulating");

endmodule

// ===== design/bis_out.sv =====
// ----------------------------------------------------------------------------
// bis_out
// Merge stage: packs the lane results into the result register.
// ----------------------------------------------------------------------------
module bis_out import bis_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  bis_out_ctl_t      ctl,
    input  logic [CHAN_W-1:0] chan [NUM_LANES],
    output logic              free,
    bis_pix_if.source         result
);

    logic              valid_reg;
    logic              valid_next;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic              last_reg;

    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            red_reg   <= chan[0];
            green_reg <= chan[1];
            blue_reg  <= chan[2];
            last_reg  <= ctl.last;
        end
    end

    assign result.valid      = valid_reg;
    assign result.red_out    = red_reg;
    assign result.green_out  = green_reg;
    assign result.blue_out   = blue_reg;
    assign result.frame_last = last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> (!valid_reg || result.ready))
        else $error("result register overwritten before taken");

endmodule

// ===== design/bilinear_image_scaler.sv =====
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// Bilinear RGB scaler: frame store, address sequencer, three channel lanes.
// ----------------------------------------------------------------------------
// channel        role     contents
// command_chan   sink     command, red_in, green_in, blue_in
// result_chan    source   red_out, green_out, blue_out, frame_last
// cfg_*          write    cfg_write_en, cfg_index, cfg_data
//
// a load request writes the pixel to the frame store
// a produce request steps through position multiply, index clamp, row base
// multiply, four reads through the single frame store port, last accumulate,
// hand-off; the hand-off waits while the result register is still occupied
// reset restores counters, state and config; the frame store is not cleared
// a request is taken only when the sequencer is idle
// ----------------------------------------------------------------------------
module bilinear_image_scaler import bis_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bis_cmd_if.sink               command_chan,
    bis_pix_if.source             result_chan,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SIZE_W      = $clog2(STORE_DEPTH + 1);
    localparam int W_W         = $clog2(MAX_WIDTH + 1);
    localparam int H_W         = $clog2(MAX_HEIGHT + 1);
    localparam int XI_W        = $clog2(MAX_WIDTH);
    localparam int YI_W        = $clog2(MAX_HEIGHT);
    localparam int POS_W       = OUT_CNT_W + STEP_W;
    localparam int IP_W        = POS_W - FRAC_BITS;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_POS    = 7'b0000010,
        S_IDX    = 7'b0000100,
        S_BASE   = 7'b0001000,
        S_FETCH  = 7'b0010000,
        S_DRAIN  = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    // configuration registers
    logic [IN_DIM_W-1:0]  in_width_reg;
    logic [IN_DIM_W-1:0]  in_height_reg;
    logic [OUT_DIM_W-1:0] out_width_reg;
    logic [OUT_DIM_W-1:0] out_height_reg;
    logic [STEP_W-1:0]    x_step_reg;
    logic [STEP_W-1:0]    y_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg   <= IN_WIDTH_RST;
            in_height_reg  <= IN_HEIGHT_RST;
            out_width_reg  <= OUT_WIDTH_RST;
            out_height_reg <= OUT_HEIGHT_RST;
            x_step_reg     <= X_STEP_RST;
            y_step_reg     <= Y_STEP_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_IN_WIDTH:   in_width_reg   <= cfg_data[IN_DIM_W-1:0];
                REG_IN_HEIGHT:  in_height_reg  <= cfg_data[IN_DIM_W-1:0];
                REG_OUT_WIDTH:  out_width_reg  <= cfg_data[OUT_DIM_W-1:0];
                REG_OUT_HEIGHT: out_height_reg <= cfg_data[OUT_DIM_W-1:0];
                REG_X_STEP:     x_step_reg     <= cfg_data[STEP_W-1:0];
                REG_Y_STEP:     y_step_reg     <= cfg_data[STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    // effective sizes
    logic [W_W-1:0]       eff_w;
    logic [H_W-1:0]       eff_h;
    logic [OUT_DIM_W-1:0] eff_ow;
    logic [OUT_DIM_W-1:0] eff_oh;
    logic [SIZE_W-1:0]    store_size;

    always_comb
    begin
        int unsigned tw;
        int unsigned th;
        int unsigned tow;
        int unsigned toh;
        tw  = 32'(in_width_reg);
        th  = 32'(in_height_reg);
        tow = 32'(out_width_reg);
        toh = 32'(out_height_reg);
        if (tw < 2) tw = 2;
        if (tw > MAX_WIDTH) tw = MAX_WIDTH;
        if (th < 2) th = 2;
        if (th > MAX_HEIGHT) th = MAX_HEIGHT;
        if (tow < 1) tow = 1;
        if (tow > OUT_MAX) tow = OUT_MAX;
        if (toh < 1) toh = 1;
        if (toh > OUT_MAX) toh = OUT_MAX;
        eff_w  = W_W'(tw);
        eff_h  = H_W'(th);
        eff_ow = OUT_DIM_W'(tow);
        eff_oh = OUT_DIM_W'(toh);
    end

    assign store_size = SIZE_W'(eff_w) * SIZE_W'(eff_h);

    // sequencer state
    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      load_addr_reg, load_addr_next;
    logic [OUT_CNT_W-1:0]   col_reg, col_next;
    logic [OUT_CNT_W-1:0]   row_reg, row_next;
    logic [OUT_CNT_W-1:0]   col_cap_reg, row_cap_reg;
    logic                   last_cap_reg;
    logic [POS_W-1:0]       pos_x_reg, pos_y_reg;
    logic [XI_W-1:0]        x0_reg, x1_reg;
    logic [YI_W-1:0]        y0_reg, y1_reg;
    logic [CHAN_W-1:0]      fx_reg, fy_reg;
    logic [ADDR_W-1:0]      base0_reg, base1_reg;
    logic [1:0]             cnt_reg;
    logic                   rd_vld_reg;
    logic [WEIGHT_W-1:0]    weight_reg, weight_next;

    logic                   accept;
    logic                   load_req;
    logic                   produce_req;
    logic                   out_free;

    assign command_chan.ready = (state_reg == S_IDLE);
    assign accept      = command_chan.valid && command_chan.ready;
    assign load_req    = accept && !command_chan.command;
    assign produce_req = accept && command_chan.command;

    // load address, stale value taken as zero
    logic [ADDR_W-1:0] load_eff;
    logic [SIZE_W-1:0] load_inc;

    always_comb
    begin
        load_eff       = (SIZE_W'(load_addr_reg) >= store_size) ? '0 : load_addr_reg;
        load_inc       = SIZE_W'(load_eff) + SIZE_W'(1);
        load_addr_next = load_addr_reg;
        if (load_req)
        begin
            load_addr_next = (load_inc >= store_size) ? '0 : ADDR_W'(load_inc);
        end
    end

    // output raster counters
    logic [OUT_CNT_W-1:0] col_eff, row_eff;
    logic [OUT_DIM_W-1:0] col_inc, row_inc;
    logic                 col_wrap;
    logic                 last_now;

    always_comb
    begin
        col_eff  = ({1'b0, col_reg} >= eff_ow) ? '0 : col_reg;
        row_eff  = ({1'b0, row_reg} >= eff_oh) ? '0 : row_reg;
        col_inc  = {1'b0, col_eff} + OUT_DIM_W'(1);
        row_inc  = {1'b0, row_eff} + OUT_DIM_W'(1);
        col_wrap = (col_inc >= eff_ow);
        last_now = ({1'b0, col_eff} == eff_ow - OUT_DIM_W'(1)) &&
                   ({1'b0, row_eff} == eff_oh - OUT_DIM_W'(1));
        col_next = col_reg;
        row_next = row_reg;
        if (produce_req)
        begin
            col_next = col_wrap ? '0 : col_inc[OUT_CNT_W-1:0];
            if (col_wrap)
            begin
                row_next = (row_inc >= eff_oh) ? '0 : row_inc[OUT_CNT_W-1:0];
            end
            else
            begin
                row_next = row_eff;
            end
        end
    end

    // neighbor indices, clamped at the right and bottom edges
    logic [IP_W-1:0] ip_x, ip_y;
    logic [W_W-1:0]  wm1;
    logic [H_W-1:0]  hm1;
    logic            x_edge, y_edge;
    logic [XI_W-1:0] x0_next, x1_next;
    logic [YI_W-1:0] y0_next, y1_next;

    always_comb
    begin
        ip_x    = pos_x_reg[POS_W-1:FRAC_BITS];
        ip_y    = pos_y_reg[POS_W-1:FRAC_BITS];
        wm1     = eff_w - W_W'(1);
        hm1     = eff_h - H_W'(1);
        x_edge  = (ip_x >= wm1);
        y_edge  = (ip_y >= hm1);
        x0_next = x_edge ? XI_W'(wm1) : XI_W'(ip_x);
        x1_next = x_edge ? XI_W'(wm1) : XI_W'(ip_x) + XI_W'(1);
        y0_next = y_edge ? YI_W'(hm1) : YI_W'(ip_y);
        y1_next = y_edge ? YI_W'(hm1) : YI_W'(ip_y) + YI_W'(1);
    end

    // read address and weight of neighbor a, b, c, d in turn
    logic [ADDR_W-1:0] rd_addr;
    logic [8:0]        xw, yw;

    always_comb
    begin
        rd_addr     = (cnt_reg[1] ? base1_reg : base0_reg) +
                      ADDR_W'(cnt_reg[0] ? x1_reg : x0_reg);
        xw          = cnt_reg[0] ? {1'b0, fx_reg} : 9'd256 - {1'b0, fx_reg};
        yw          = cnt_reg[1] ? {1'b0, fy_reg} : 9'd256 - {1'b0, fy_reg};
        weight_next = WEIGHT_W'(xw) * WEIGHT_W'(yw);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (produce_req) state_next = S_POS;
            S_POS:    state_next = S_IDX;
            S_IDX:    state_next = S_BASE;
            S_BASE:   state_next = S_FETCH;
            S_FETCH:  if (cnt_reg == 2'd3) state_next = S_DRAIN;
            S_DRAIN:  state_next = S_FINISH;
            S_FINISH: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            load_addr_reg <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_addr_reg <= load_addr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= (state_reg == S_FETCH) ? cnt_reg + 2'd1 : 2'd0;
            rd_vld_reg    <= (state_reg == S_FETCH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce_req)
        begin
            col_cap_reg  <= col_eff;
            row_cap_reg  <= row_eff;
            last_cap_reg <= last_now;
        end
        if (state_reg == S_POS)
        begin
            pos_x_reg <= POS_W'(col_cap_reg) * POS_W'(x_step_reg);
            pos_y_reg <= POS_W'(row_cap_reg) * POS_W'(y_step_reg);
        end
        if (state_reg == S_IDX)
        begin
            x0_reg <= x0_next;
            x1_reg <= x1_next;
            y0_reg <= y0_next;
            y1_reg <= y1_next;
            fx_reg <= pos_x_reg[FRAC_BITS-1 -: CHAN_W];
            fy_reg <= pos_y_reg[FRAC_BITS-1 -: CHAN_W];
        end
        if (state_reg == S_BASE)
        begin
            base0_reg <= ADDR_W'(y0_reg) * ADDR_W'(eff_w);
            base1_reg <= ADDR_W'(y1_reg) * ADDR_W'(eff_w);
        end
        weight_reg <= weight_next;
    end

    // frame store
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0]  ram_wdata;
    logic [PIX_W-1:0]  ram_rdata;

    assign ram_addr  = (state_reg == S_FETCH) ? rd_addr : load_eff;
    assign ram_wdata = {command_chan.red_in, command_chan.green_in, command_chan.blue_in};

    bis_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (load_req),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // channel lanes, red first
    bis_lane_ctl_t     lane_ctl;
    logic [CHAN_W-1:0] lane_chan [NUM_LANES];

    assign lane_ctl.clear  = produce_req;
    assign lane_ctl.mac_en = rd_vld_reg;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        bis_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (lane_ctl),
            .pix    (ram_rdata[PIX_W-1-g*CHAN_W -: CHAN_W]),
            .weight (weight_reg),
            .chan   (lane_chan[g])
        );
    end

    bis_out_ctl_t out_ctl;

    assign out_ctl.load = (state_reg == S_FINISH) && out_free;
    assign out_ctl.last = last_cap_reg;

    bis_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (out_ctl),
        .chan   (lane_chan),
        .free   (out_free),
        .result (result_chan)
    );

    a_four_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BASE) |=> ##4 (state_reg == S_DRAIN))
        else $error("fetch did not take four reads");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !out_free) |=> (state_reg == S_FINISH))
        else $error("result dropped while result register busy");

    a_no_write_in_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> !load_req)
        else $error("frame store written during neighbor reads");

endmodule
